>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, disabled while reset is asserted
`define U8_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8u16: assertion failed");

// clocked check that also holds during reset
`define U8_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("u8u16: assertion failed");

`else

`define U8_ASSERT(lbl, clk, rst_n, prop)
`define U8_ASSERT_NR(lbl, clk, prop)

`endif

`endif

>>> sv/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and decode helpers shared by the UTF-8 to UTF-16 blocks.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_REPL_CP   = 1'b0;
    localparam logic REG_REPL_UNIT = 1'b1;

    // field widths
    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;

    // code point limits and surrogate constants
    localparam logic [31:0]       CP_MAX        = 32'h0010_FFFF;
    localparam logic [15:0]       SURR_LO       = 16'hD800;
    localparam logic [15:0]       SURR_HI       = 16'hDFFF;
    localparam logic [15:0]       LOW_SURR_BASE = 16'hDC00;
    localparam logic [CP_W-1:0]   SUPP_BASE     = 21'h01_0000;
    localparam logic [5:0]        HI_SURR_TAG   = 6'b110110;

    // decoupling queue (depth must be a power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    // one classified item: a single unit, or a surrogate pair
    typedef struct packed {
        logic              pair;
        logic [UNIT_W-1:0] unit0;
        logic [UNIT_W-1:0] unit1;
        logic              text_last;
    } t_q_item;

    // sequence length from the lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        priority if (b < 8'd192) len = 3'd1;
        else if (b < 8'd224)     len = 3'd2;
        else if (b < 8'd240)     len = 3'd3;
        else if (b < 8'd248)     len = 3'd4;
        else if (b < 8'd252)     len = 3'd5;
        else                     len = 3'd6;
        return len;
    endfunction

    // marker-bit offset removed from the accumulated value
    function automatic logic [31:0] seq_offset(input logic [2:0] len);
        logic [31:0] off;
        unique case (len)
            3'd2:    off = 32'h0000_3080;
            3'd3:    off = 32'h000E_2080;
            3'd4:    off = 32'h03C8_2080;
            3'd5:    off = 32'hFA08_2080;
            3'd6:    off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

>>> sv/u8u16_if.sv
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Byte input channel and UTF-16 unit output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_last;
    logic        text_last;

    modport source (output valid, output code_unit, output run_last, output text_last,
                    input ready);
    modport sink   (input valid, input code_unit, input run_last, input text_last,
                    output ready);
endinterface

>>> sv/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, accumulates sequences and classifies finished code points.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u16_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    u8u16_in_if.sink                       i_in,
    input  logic [u8u16_pkg::CP_W-1:0]     i_repl_cp,
    input  logic [u8u16_pkg::UNIT_W-1:0]   i_repl_unit,
    input  logic                           i_q_ready,
    output logic                           o_q_push,
    output u8u16_pkg::t_q_item             o_q_item
);

    logic [2:0]  r_rem;
    logic [2:0]  r_len;
    logic [31:0] r_acc;

    logic        accept;
    logic [2:0]  n_rem;
    logic [2:0]  n_len;
    logic [31:0] n_acc;
    logic        done;
    logic        emit;
    logic [31:0] cp;
    logic [u8u16_pkg::CP_W-1:0] supp;

    // a byte is taken whenever the queue has room
    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid & i_in.ready;

    // sequence tracking
    always_comb begin
        if (r_rem == 3'd0) begin
            n_len = u8u16_pkg::lead_length(i_in.text_byte);
            n_rem = n_len - 3'd1;
            n_acc = {24'd0, i_in.text_byte};
        end else begin
            n_len = r_len;
            n_rem = r_rem - 3'd1;
            n_acc = {r_acc[25:0], 6'd0} + {24'd0, i_in.text_byte};
        end
    end

    assign done = (n_rem == 3'd0);
    assign emit = accept & (done | i_in.last_byte);

    // finished code point, or the substitute when the text ends early
    assign cp   = done ? (n_acc - u8u16_pkg::seq_offset(n_len))
                       : {{(32-u8u16_pkg::CP_W){1'b0}}, i_repl_cp};
    assign supp = cp[u8u16_pkg::CP_W-1:0] - u8u16_pkg::SUPP_BASE;

    // classify into a single unit or a surrogate pair
    always_comb begin
        o_q_item.pair      = 1'b0;
        o_q_item.unit0     = cp[15:0];
        o_q_item.unit1     = u8u16_pkg::LOW_SURR_BASE | {6'd0, supp[9:0]};
        o_q_item.text_last = i_in.last_byte;
        priority if (cp > u8u16_pkg::CP_MAX) begin
            o_q_item.unit0 = i_repl_unit;
        end else if (cp[31:16] == 16'd0) begin
            if (cp[15:0] >= u8u16_pkg::SURR_LO && cp[15:0] <= u8u16_pkg::SURR_HI) begin
                o_q_item.unit0 = i_repl_unit;
            end
        end else begin
            o_q_item.pair  = 1'b1;
            o_q_item.unit0 = u8u16_pkg::SURR_LO | {6'd0, supp[19:10]};
        end
    end

    assign o_q_push = emit;

    // state registers; cleared after every emitted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
            r_len <= 3'd0;
            r_acc <= 32'd0;
        end else if (accept) begin
            if (done | i_in.last_byte) begin
                r_rem <= 3'd0;
                r_len <= 3'd0;
                r_acc <= 32'd0;
            end else begin
                r_rem <= n_rem;
                r_len <= n_len;
                r_acc <= n_acc;
            end
        end
    end

    // end of text always leaves a clean decoder
    `U8_ASSERT(a_front_clear, i_clk, i_rst_n, (accept && i_in.last_byte) |=> (r_rem == 3'd0 && r_len == 3'd0))
    // mid-sequence the length is a multi-byte one
    `U8_ASSERT(a_front_len, i_clk, i_rst_n, (r_rem != 3'd0) |-> (r_len > r_rem))

endmodule

>>> sv/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u16_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8u16_pkg::t_q_item   i_item,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_valid,
    output u8u16_pkg::t_q_item   o_item
);

    u8u16_pkg::t_q_item r_mem [u8u16_pkg::QDEPTH];
    u8u16_pkg::t_qptr   r_wptr;
    u8u16_pkg::t_qptr   r_rptr;
    u8u16_pkg::t_qcnt   r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != u8u16_pkg::t_qcnt'(u8u16_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= u8u16_pkg::t_qptr'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= u8u16_pkg::t_qptr'(r_rptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= u8u16_pkg::t_qcnt'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= u8u16_pkg::t_qcnt'(r_count - 1'b1);
            end
        end
    end

    `U8_ASSERT(a_q_bound, i_clk, i_rst_n, (r_count <= u8u16_pkg::t_qcnt'(u8u16_pkg::QDEPTH)))
    `U8_ASSERT(a_q_nopush_full, i_clk, i_rst_n, i_push |-> o_ready)
    `U8_ASSERT(a_q_nopop_empty, i_clk, i_rst_n, i_pop |-> o_valid)

endmodule

>>> sv/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Drains queued items to the output reg, one UTF-16 unit per unstalled cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u16_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  u8u16_pkg::t_q_item   i_q_item,
    output logic                 o_pop,
    u8u16_out_if.source          o_out
);

    logic                              r_valid;
    logic [u8u16_pkg::UNIT_W-1:0]      r_unit;
    logic                              r_run_last;
    logic                              r_text_last;
    logic                              r_phase;

    logic load;
    logic take;
    logic final_unit;

    // output register refills when empty or being drained
    assign load       = ~r_valid | o_out.ready;
    assign take       = load & i_q_valid;
    assign final_unit = ~i_q_item.pair | r_phase;
    assign o_pop      = take & final_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_phase <= ~final_unit;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_unit      <= r_phase ? i_q_item.unit1 : i_q_item.unit0;
            r_run_last  <= final_unit;
            r_text_last <= final_unit & i_q_item.text_last;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.code_unit = r_unit;
    assign o_out.run_last  = r_run_last;
    assign o_out.text_last = r_text_last;

    // second half of a pair keeps its item at the queue head
    `U8_ASSERT(a_back_phase, i_clk, i_rst_n, r_phase |-> (i_q_valid && i_q_item.pair))
    // a unit that does not end its run is a high surrogate
    `U8_ASSERT(a_back_hi, i_clk, i_rst_n, (r_valid && !r_run_last) |-> (r_unit[15:10] == u8u16_pkg::HI_SURR_TAG && !r_text_last))

endmodule

>>> sv/utf8_to_utf16_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units out, APB replacement registers.
//
//   channel   dir   handshake       payload
//   i_in      in    valid/ready     text_byte[7:0], last_byte
//   o_out     out   valid/ready     code_unit[15:0], run_last, text_last
//   apb       in    psel/penable    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One byte is accepted per cycle while the queue has room; a finished item is
// written into the queue and then into the output register when o_out is free.
// A surrogate pair occupies the single output register for both its units; a
// byte right behind a pair can wait for room in the 2-entry queue.
// Reset (synchronous, active low) clears registers, queue and decoder state.
// A stall on o_out backs up into the queue and then drops i_in.ready.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    u8u16_in_if.sink                            i_in,
    u8u16_out_if.source                         o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [u8u16_pkg::PADDR_W-1:0]       paddr,
    input  logic [u8u16_pkg::PDATA_W-1:0]       pwdata,
    output logic [u8u16_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    logic [u8u16_pkg::CP_W-1:0]   r_repl_cp;
    logic [u8u16_pkg::UNIT_W-1:0] r_repl_unit;

    logic                 reg_idx;
    logic                 wr_en;
    logic                 q_push;
    logic                 q_ready;
    logic                 q_valid;
    logic                 q_pop;
    u8u16_pkg::t_q_item   q_in_item;
    u8u16_pkg::t_q_item   q_out_item;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl_cp   <= '0;
            r_repl_unit <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                u8u16_pkg::REG_REPL_CP:   r_repl_cp   <= pwdata[u8u16_pkg::CP_W-1:0];
                u8u16_pkg::REG_REPL_UNIT: r_repl_unit <= pwdata[u8u16_pkg::UNIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            u8u16_pkg::REG_REPL_CP:
                prdata = {{(u8u16_pkg::PDATA_W-u8u16_pkg::CP_W){1'b0}}, r_repl_cp};
            u8u16_pkg::REG_REPL_UNIT:
                prdata = {{(u8u16_pkg::PDATA_W-u8u16_pkg::UNIT_W){1'b0}}, r_repl_unit};
            default:
                prdata = '0;
        endcase
    end

    // decode and classify
    u8u16_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_repl_cp   (r_repl_cp),
        .i_repl_unit (r_repl_unit),
        .i_q_ready   (q_ready),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item)
    );

    // decoupling queue
    u8u16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    // unit emitter
    u8u16_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_out_item),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
